>>> rtl/core/nbb_pkg.sv
// nibble bitmap blitter: shared types, constants and register codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nbb_pkg;

  localparam int DIM_W = 11;
  localparam int COORD_W = 16;
  localparam int NIB_W = 4;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;
  localparam logic [DIM_W-1:0] DIM_ONE = 11'd1;
  localparam logic [DIM_W-1:0] COL_STEP = 11'd2;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_ROTATION = 3'd4,
    REG_MIRROR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    rot_t               rotation;
    logic               mirror;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] rev_col;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] rev_row;
    logic [NIB_W-1:0] nib_hi;
    logic [NIB_W-1:0] nib_lo;
    logic             v_hi;
    logic             v_lo;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_ONE;
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/nbb_regs.sv
// nibble bitmap blitter: apb-style configuration registers
// depends on nbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module nbb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nbb_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [nbb_pkg::DATA_W-1:0]  pwdata,
  output logic      [nbb_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output nbb_pkg::cfg_t                    cfg
);

  logic [nbb_pkg::COORD_W-1:0] origin_x_r, origin_x_nxt;
  logic [nbb_pkg::COORD_W-1:0] origin_y_r, origin_y_nxt;
  logic [nbb_pkg::DIM_W-1:0]   width_r, width_nxt;
  logic [nbb_pkg::DIM_W-1:0]   height_r, height_nxt;
  nbb_pkg::rot_t               rotation_r, rotation_nxt;
  logic                        mirror_r, mirror_nxt;
  nbb_pkg::reg_idx_t           reg_idx;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = nbb_pkg::reg_idx_t'(paddr[nbb_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    rotation_nxt = rotation_r;
    mirror_nxt   = mirror_r;
    if (wr_en) begin
      case (reg_idx)
        nbb_pkg::REG_ORIGIN_X: origin_x_nxt = pwdata[nbb_pkg::COORD_W-1:0];
        nbb_pkg::REG_ORIGIN_Y: origin_y_nxt = pwdata[nbb_pkg::COORD_W-1:0];
        nbb_pkg::REG_WIDTH:    width_nxt = pwdata[nbb_pkg::DIM_W-1:0];
        nbb_pkg::REG_HEIGHT:   height_nxt = pwdata[nbb_pkg::DIM_W-1:0];
        nbb_pkg::REG_ROTATION: rotation_nxt = nbb_pkg::rot_t'(pwdata[1:0]);
        nbb_pkg::REG_MIRROR:   mirror_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= nbb_pkg::DIM_ONE;
      height_r   <= nbb_pkg::DIM_ONE;
      rotation_r <= nbb_pkg::ROT_0;
      mirror_r   <= 1'b0;
    end else begin
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      rotation_r <= rotation_nxt;
      mirror_r   <= mirror_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      nbb_pkg::REG_ORIGIN_X: prdata[nbb_pkg::COORD_W-1:0] = origin_x_r;
      nbb_pkg::REG_ORIGIN_Y: prdata[nbb_pkg::COORD_W-1:0] = origin_y_r;
      nbb_pkg::REG_WIDTH:    prdata[nbb_pkg::DIM_W-1:0] = width_r;
      nbb_pkg::REG_HEIGHT:   prdata[nbb_pkg::DIM_W-1:0] = height_r;
      nbb_pkg::REG_ROTATION: prdata[1:0] = rotation_r;
      nbb_pkg::REG_MIRROR:   prdata[0] = mirror_r;
      default: ;
    endcase
  end

  // sizes take effect clamped
  always_comb begin
    cfg.origin_x = origin_x_r;
    cfg.origin_y = origin_y_r;
    cfg.width    = nbb_pkg::clamp_dim(width_r);
    cfg.height   = nbb_pkg::clamp_dim(height_r);
    cfg.rotation = rotation_r;
    cfg.mirror   = mirror_r;
  end

endmodule

`default_nettype wire

>>> rtl/core/nbb_front.sv
// nibble bitmap blitter: byte intake, row and column tracking, job build
// depends on nbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module nbb_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire nbb_pkg::cfg_t              cfg,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic                       in_first_byte,
  input  wire logic [7:0]                 in_pixel_pair,
  input  wire nbb_pkg::q_stat_t           q_stat,
  output logic                            job_push,
  output nbb_pkg::job_t                   job
);

  logic [nbb_pkg::DIM_W-1:0] col_r, col_nxt;
  logic [nbb_pkg::DIM_W-1:0] row_r, row_nxt;
  logic                      done_r, done_nxt;
  logic                      accept;
  logic                      active;
  logic                      in_image;
  logic [nbb_pkg::DIM_W-1:0] eff_col;
  logic [nbb_pkg::DIM_W-1:0] eff_row;
  logic [nbb_pkg::DIM_W-1:0] col_plus1;
  logic [nbb_pkg::DIM_W-1:0] col_plus2;
  logic [nbb_pkg::DIM_W-1:0] row_plus1;
  logic [nbb_pkg::NIB_W-1:0] nib_hi;
  logic [nbb_pkg::NIB_W-1:0] nib_lo;

  assign in_full   = q_stat.full;
  assign accept    = in_push && !q_stat.full;
  assign active    = accept && (in_first_byte || !done_r);
  assign eff_col   = in_first_byte ? '0 : col_r;
  assign eff_row   = in_first_byte ? '0 : row_r;
  assign in_image  = eff_row < cfg.height;
  assign col_plus1 = eff_col + nbb_pkg::DIM_ONE;
  assign col_plus2 = eff_col + nbb_pkg::COL_STEP;
  assign row_plus1 = eff_row + nbb_pkg::DIM_ONE;
  assign nib_hi    = in_pixel_pair[7:4];
  assign nib_lo    = in_pixel_pair[3:0];

  always_comb begin
    job.col     = eff_col;
    job.rev_col = cfg.width - nbb_pkg::DIM_ONE - eff_col;
    job.row     = eff_row;
    job.rev_row = cfg.height - nbb_pkg::DIM_ONE - eff_row;
    job.nib_hi  = nib_hi;
    job.nib_lo  = nib_lo;
    job.v_hi    = (eff_col < cfg.width) && (nib_hi != '0);
    job.v_lo    = (col_plus1 < cfg.width) && (nib_lo != '0);
  end

  assign job_push = active && in_image && (job.v_hi || job.v_lo);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    done_nxt = done_r;
    if (active) begin
      col_nxt  = eff_col;
      row_nxt  = eff_row;
      done_nxt = 1'b0;
      if (!in_image) begin
        done_nxt = 1'b1;
      end else if (col_plus2 >= cfg.width) begin
        col_nxt  = '0;
        row_nxt  = row_plus1;
        done_nxt = row_plus1 >= cfg.height;
      end else begin
        col_nxt = col_plus2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      done_r <= 1'b1;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nbb_queue.sv
// nibble bitmap blitter: two-entry job queue between front and back
// depends on nbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module nbb_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire nbb_pkg::job_t     din,
  input  wire logic              pop,
  output nbb_pkg::job_t          dout,
  output nbb_pkg::q_stat_t       stat
);

  nbb_pkg::job_t mem [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nbb_back.sv
// nibble bitmap blitter: pixel placement and output register
// depends on nbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module nbb_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire nbb_pkg::cfg_t               cfg,
  input  wire nbb_pkg::job_t               head,
  input  wire nbb_pkg::q_stat_t            q_stat,
  output logic                             job_pop,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [nbb_pkg::COORD_W-1:0]      pix_x,
  output logic [nbb_pkg::COORD_W-1:0]      pix_y,
  output logic [nbb_pkg::NIB_W-1:0]        color,
  output logic                             last_of_byte
);

  logic                        phase_r, phase_nxt;
  logic                        valid_r, valid_nxt;
  logic [nbb_pkg::COORD_W-1:0] x_r, x_nxt;
  logic [nbb_pkg::COORD_W-1:0] y_r, y_nxt;
  logic [nbb_pkg::NIB_W-1:0]   color_r, color_nxt;
  logic                        last_r, last_nxt;
  logic                        slot_free;
  logic                        emit;
  logic                        emit_hi;
  logic [nbb_pkg::DIM_W-1:0]   i_val;
  logic [nbb_pkg::DIM_W-1:0]   rev_i;
  logic [nbb_pkg::DIM_W-1:0]   dx;
  logic [nbb_pkg::DIM_W-1:0]   dy;

  assign slot_free = !valid_r || out_pop;
  assign emit      = !q_stat.empty && slot_free;
  assign emit_hi   = !phase_r && head.v_hi;
  assign job_pop   = emit && !(emit_hi && head.v_lo);
  assign i_val     = emit_hi ? head.col : head.col + nbb_pkg::DIM_ONE;
  assign rev_i     = emit_hi ? head.rev_col : head.rev_col - nbb_pkg::DIM_ONE;

  always_comb begin
    case (cfg.rotation)
      nbb_pkg::ROT_0: begin
        dx = i_val;
        dy = cfg.mirror ? head.rev_row : head.row;
      end
      nbb_pkg::ROT_90: begin
        dx = cfg.mirror ? head.row : head.rev_row;
        dy = i_val;
      end
      nbb_pkg::ROT_180: begin
        dx = rev_i;
        dy = cfg.mirror ? head.row : head.rev_row;
      end
      nbb_pkg::ROT_270: begin
        dx = cfg.mirror ? head.rev_row : head.row;
        dy = rev_i;
      end
      default: begin
        dx = i_val;
        dy = head.row;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    color_nxt = color_r;
    last_nxt  = last_r;
    if (out_pop) begin
      valid_nxt = 1'b0;
    end
    if (emit) begin
      valid_nxt = 1'b1;
      phase_nxt = emit_hi && head.v_lo;
      x_nxt     = cfg.origin_x + {{(nbb_pkg::COORD_W-nbb_pkg::DIM_W){1'b0}}, dx};
      y_nxt     = cfg.origin_y + {{(nbb_pkg::COORD_W-nbb_pkg::DIM_W){1'b0}}, dy};
      color_nxt = emit_hi ? head.nib_hi : head.nib_lo;
      last_nxt  = !(emit_hi && head.v_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    color_r <= color_nxt;
    last_r  <= last_nxt;
  end

  assign out_empty    = !valid_r;
  assign pix_x        = x_r;
  assign pix_y        = y_r;
  assign color        = color_r;
  assign last_of_byte = last_r;

`ifndef SYNTHESIS
  a_color_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> color_r != '0)
    else $error("pixel write with transparent colour");

  a_phase_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!q_stat.empty && head.v_lo))
    else $error("low nibble pending without a job holding it");

  a_hi_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_hi && head.v_lo) |=> (phase_r && !last_r))
    else $error("split byte did not leave the low nibble pending");
`endif

endmodule

`default_nettype wire

>>> rtl/core/nibble_bitmap_blitter.sv
// path: an accepted byte passes through a job queue entry, then the output register
// throughput: one byte a cycle while in_full is low and it yields at most one write;
// one pixel write a cycle on the result side while out_pop keeps the output free,
// set by the single placement adder pair
// reset: synchronous rst_n restores register defaults, empties queue and output,
// and leaves the block idle until a byte marked first_byte arrives
`timescale 1ns / 1ps
`default_nettype none

module nibble_bitmap_blitter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nbb_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [nbb_pkg::DATA_W-1:0]  pwdata,
  output logic      [nbb_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic                        in_first_byte,
  input  wire logic [7:0]                  in_pixel_pair,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic signed [15:0]               out_pixel_x,
  output logic signed [15:0]               out_pixel_y,
  output logic      [3:0]                  out_color,
  output logic                             out_last_of_byte
);

  nbb_pkg::cfg_t     cfg;
  nbb_pkg::job_t     job_in;
  nbb_pkg::job_t     job_head;
  nbb_pkg::q_stat_t  q_stat;
  logic              job_push;
  logic              job_pop;
  logic [15:0]       pix_x;
  logic [15:0]       pix_y;

  nbb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nbb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_first_byte (in_first_byte),
    .in_pixel_pair (in_pixel_pair),
    .q_stat        (q_stat),
    .job_push      (job_push),
    .job           (job_in)
  );

  nbb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_head),
    .stat  (q_stat)
  );

  nbb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .head         (job_head),
    .q_stat       (q_stat),
    .job_pop      (job_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .color        (out_color),
    .last_of_byte (out_last_of_byte)
  );

  assign out_pixel_x = $signed(pix_x);
  assign out_pixel_y = $signed(pix_y);

endmodule

`default_nettype wire
